[design/hsmtp_pkg.sv]
// ----------------------------------------------------------------------------
// hsmtp_pkg: shared types and constants of the transition planner
// Request and result codes, table entry layout, queue and sequencer types.
// ----------------------------------------------------------------------------
package hsmtp_pkg;

  localparam int NumStates   = 64;
  localparam int SlotW       = $clog2(NumStates);
  localparam int MaxDepth    = 16;
  localparam int DepthW      = $clog2(MaxDepth);
  localparam int LenW        = $clog2(MaxDepth + 1);
  localparam int MaxResults  = 32;
  localparam int ResW        = $clog2(MaxResults + 1);
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam logic [31:0] RootReset = 32'h822E39A8;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_PLAN  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    KIND_EXIT   = 3'd0,
    KIND_ENTRY  = 3'd1,
    KIND_FOUND  = 3'd2,
    KIND_NONE   = 3'd3,
    KIND_ABSENT = 3'd4
  } step_kind_e;

  typedef struct packed {
    req_type_e        kind;
    logic [SlotW-1:0] slot;
    logic [31:0]      handler;
    logic [31:0]      parent;
    logic [8:0]       code;
    logic [31:0]      from_state;
    logic [31:0]      to_state;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

  typedef struct packed {
    logic [31:0] handler;
    logic [31:0] parent;
    logic [8:0]  code;
  } entry_t;

  typedef struct packed {
    step_kind_e  kind;
    logic [31:0] state;
    logic [7:0]  code;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ISSUE,
    B_CMP,
    B_END,
    B_WALK,
    B_COMMON,
    B_GEN,
    B_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    P_QUERY,
    P_FROM,
    P_TO,
    P_WALK
  } lookup_purpose_e;

endpackage

[design/hsmtp_if.sv]
// ----------------------------------------------------------------------------
// hsmtp_req_if / hsmtp_rsp_if: request and result channels
// Valid/ready channels carrying the planner request and result fields.
// ----------------------------------------------------------------------------
interface hsmtp_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [5:0]        slot;
  logic [31:0]       entry_handler;
  logic [31:0]       entry_parent;
  logic signed [8:0] load_code;
  logic [31:0]       from_state;
  logic [31:0]       to_state;

  modport source (output valid, req_type, slot, entry_handler, entry_parent,
                  load_code, from_state, to_state, input ready);
  modport sink (input valid, req_type, slot, entry_handler, entry_parent,
                load_code, from_state, to_state, output ready);
endinterface

interface hsmtp_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  step_kind;
  logic [31:0] step_state;
  logic [7:0]  code_value;
  logic        last;

  modport source (output valid, step_kind, step_state, code_value, last,
                  input ready);
  modport sink (input valid, step_kind, step_state, code_value, last,
                output ready);
endinterface

[design/hsmtp_front.sv]
// ----------------------------------------------------------------------------
// hsmtp_front: request intake
// Accepts requests, drops unused codes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module hsmtp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsmtp_req_if.sink            req_i,
  output hsmtp_pkg::queue_head_t head_o,
  input  logic                 pop_i
);
  import hsmtp_pkg::*;

  req_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             push;
  req_t             req_in;

  // classify the incoming request
  always_comb begin
    req_in.kind       = req_type_e'(req_i.req_type);
    req_in.slot       = req_i.slot;
    req_in.handler    = req_i.entry_handler;
    req_in.parent     = req_i.entry_parent;
    req_in.code       = req_i.load_code;
    req_in.from_state = req_i.from_state;
    req_in.to_state   = req_i.to_state;
  end

  assign req_i.ready = count_q != (QPtrW+1)'(QueueDepth);
  assign push = req_i.valid && req_i.ready && (req_in.kind != REQ_NONE);

  // store queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop_i);
    end
  end

  assign head_o.valid = count_q != '0;
  assign head_o.req   = mem_q[rd_ptr_q];
endmodule

[design/hsmtp_back.sv]
// ----------------------------------------------------------------------------
// hsmtp_back: request execution
// Owns the state table, scans it for lookups, walks ancestor chains, finds
// the common ancestor and emits results through an output register.
// ----------------------------------------------------------------------------
module hsmtp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            root_i,
  input  hsmtp_pkg::queue_head_t head_i,
  output logic                   pop_o,
  hsmtp_rsp_if.source            rsp_o
);
  import hsmtp_pkg::*;

  entry_t          table_mem [NumStates];
  logic            valid_q [NumStates];
  entry_t          rd_q;
  back_state_e     state_q, state_d;
  lookup_purpose_e purp_q, purp_d;
  req_t            req_q;
  logic [SlotW-1:0] k_q, k_d;
  logic            found_q, found_d;
  logic [31:0]     la_q, la_d;
  logic [31:0]     cur_q, cur_d;
  logic [LenW-1:0] n_q, n_d;
  logic            wsel_q, wsel_d;
  logic [LenW-1:0] from_len_q, from_len_d, to_len_q, to_len_d;
  logic [31:0]     from_chain_q [MaxDepth];
  logic [31:0]     to_chain_q [MaxDepth];
  logic [LenW-1:0] i_q, i_d, j_q, j_d, ci_q, ci_d;
  logic [ResW-1:0] nres_q, nres_d;
  rsp_t            rsp_q, rsp_d;

  logic            hit, k_last, walk_stop, look_ok, chain_eq, cap;
  logic [LenW-1:0] jm1;

  assign hit       = valid_q[k_q] && (rd_q.handler == la_q);
  assign k_last    = k_q == SlotW'(NumStates - 1);
  assign walk_stop = (cur_q == '0) || (n_q == LenW'(MaxDepth));
  assign look_ok   = found_q || (la_q == root_i);
  assign chain_eq  = from_chain_q[i_q[DepthW-1:0]] == to_chain_q[j_q[DepthW-1:0]];
  assign jm1       = j_q - 1'b1;
  assign cap       = nres_q == ResW'(MaxResults - 1);
  assign pop_o     = (state_q == B_IDLE) && head_i.valid;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.req.kind) inside
            REQ_PLAN, REQ_QUERY: state_d = B_ISSUE;
            default:             state_d = B_IDLE;
          endcase
        end
      end
      B_ISSUE: state_d = B_CMP;
      B_CMP: state_d = (hit || k_last) ? B_END : B_ISSUE;
      B_END: begin
        unique case (purp_q)
          P_QUERY: state_d = B_OUT;
          P_FROM:  state_d = look_ok ? B_ISSUE : B_OUT;
          P_TO:    state_d = look_ok ? B_WALK : B_OUT;
          default: state_d = B_WALK;
        endcase
      end
      B_WALK: begin
        if (walk_stop) state_d = wsel_q ? B_COMMON : B_WALK;
        else if (cur_q == root_i) state_d = B_WALK;
        else state_d = B_ISSUE;
      end
      B_COMMON: begin
        if (i_q == from_len_q) state_d = B_GEN;
        else if (j_q == to_len_q) state_d = B_COMMON;
        else if (chain_eq) state_d = B_GEN;
        else state_d = B_COMMON;
      end
      B_GEN: state_d = B_OUT;
      B_OUT: begin
        if (rsp_o.ready) state_d = rsp_q.last ? B_IDLE : B_GEN;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    purp_d = purp_q; k_d = k_q; found_d = found_q; la_d = la_q; cur_d = cur_q;
    n_d = n_q; wsel_d = wsel_q; from_len_d = from_len_q; to_len_d = to_len_q;
    i_d = i_q; j_d = j_q; ci_d = ci_q; nres_d = nres_q; rsp_d = rsp_q;
    unique case (state_q)
      B_IDLE: begin
        k_d  = '0;
        la_d = head_i.req.from_state;
        purp_d = (head_i.req.kind == REQ_QUERY) ? P_QUERY : P_FROM;
      end
      B_CMP: begin
        found_d = hit;
        if (!hit && !k_last) k_d = k_q + 1'b1;
      end
      B_END: begin
        k_d = '0;
        rsp_d.kind  = KIND_NONE;
        rsp_d.state = '0;
        rsp_d.code  = '0;
        rsp_d.last  = 1'b1;
        unique case (purp_q)
          P_QUERY: begin
            rsp_d.state = req_q.from_state;
            if (found_q && !rd_q.code[8]) begin
              rsp_d.kind = KIND_FOUND;
              rsp_d.code = rd_q.code[7:0];
            end else begin
              rsp_d.kind = KIND_ABSENT;
            end
          end
          P_FROM: begin
            la_d   = req_q.to_state;
            purp_d = P_TO;
          end
          P_TO: begin
            cur_d  = req_q.from_state;
            n_d    = '0;
            wsel_d = 1'b0;
          end
          default: cur_d = found_q ? rd_q.parent : '0;
        endcase
      end
      B_WALK: begin
        if (walk_stop) begin
          if (!wsel_q) begin
            from_len_d = n_q;
            wsel_d = 1'b1;
            cur_d  = req_q.to_state;
            n_d    = '0;
          end else begin
            to_len_d = n_q;
            i_d = '0;
            j_d = '0;
          end
        end else begin
          n_d = n_q + 1'b1;
          if (cur_q == root_i) begin
            cur_d = '0;
          end else begin
            la_d   = cur_q;
            purp_d = P_WALK;
          end
        end
      end
      B_COMMON: begin
        nres_d = '0;
        if (i_q == from_len_q) begin
          ci_d = from_len_q;
          i_d  = '0;
          j_d  = to_len_q;
        end else if (j_q == to_len_q) begin
          i_d = i_q + 1'b1;
          j_d = '0;
        end else if (chain_eq) begin
          ci_d = i_q;
          i_d  = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      B_GEN: begin
        nres_d = nres_q + 1'b1;
        rsp_d.code = '0;
        if (i_q < ci_q) begin
          rsp_d.kind  = KIND_EXIT;
          rsp_d.state = from_chain_q[i_q[DepthW-1:0]];
          rsp_d.last  = ((i_q + 1'b1 == ci_q) && (j_q == '0)) || cap;
          i_d = i_q + 1'b1;
        end else if (j_q != '0) begin
          rsp_d.kind  = KIND_ENTRY;
          rsp_d.state = to_chain_q[jm1[DepthW-1:0]];
          rsp_d.last  = (j_q == LenW'(1)) || cap;
          j_d = jm1;
        end else begin
          rsp_d.kind  = KIND_NONE;
          rsp_d.state = '0;
          rsp_d.last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // table storage, registered read
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.req.kind == REQ_LOAD) begin
      table_mem[head_i.req.slot] <= '{handler: head_i.req.handler,
                                      parent:  head_i.req.parent,
                                      code:    head_i.req.code};
    end
    if (state_q == B_ISSUE) begin
      rd_q <= table_mem[k_q];
    end
  end

  // chain storage and payload
  always_ff @(posedge clk_i) begin
    if (pop_o) req_q <= head_i.req;
    if (state_q == B_WALK && !walk_stop) begin
      if (wsel_q) to_chain_q[n_q[DepthW-1:0]] <= cur_q;
      else from_chain_q[n_q[DepthW-1:0]] <= cur_q;
    end
    purp_q <= purp_d; k_q <= k_d; found_q <= found_d; la_q <= la_d;
    cur_q <= cur_d; n_q <= n_d; wsel_q <= wsel_d;
    i_q <= i_d; j_q <= j_d; ci_q <= ci_d; nres_q <= nres_d; rsp_q <= rsp_d;
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      from_len_q <= '0;
      to_len_q   <= '0;
      for (int s = 0; s < NumStates; s++) valid_q[s] <= 1'b0;
    end else begin
      state_q    <= state_d;
      from_len_q <= from_len_d;
      to_len_q   <= to_len_d;
      if (pop_o && head_i.req.kind == REQ_LOAD) valid_q[head_i.req.slot] <= 1'b1;
    end
  end

  assign rsp_o.valid      = state_q == B_OUT;
  assign rsp_o.step_kind  = rsp_q.kind;
  assign rsp_o.step_state = rsp_q.state;
  assign rsp_o.code_value = rsp_q.code;
  assign rsp_o.last       = rsp_q.last;

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && rsp_q.last |=> state_q == B_IDLE)
    else $error("sequencer not idle after final result");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == B_IDLE && head_i.valid)
    else $error("queue popped while busy");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    from_len_q <= LenW'(MaxDepth) && to_len_q <= LenW'(MaxDepth))
    else $error("chain length beyond depth");
endmodule

[design/hsm_transition_planner_unit.sv]
// ----------------------------------------------------------------------------
// hsm_transition_planner_unit: hierarchical state machine transition planner
// Table of states with parent links; answers load, query and plan requests.
// ----------------------------------------------------------------------------
// A load is written into the table once it reaches the head of the request
// queue and the back end is idle. Every lookup scans the 64-slot table through
// its single read port, one slot per issue and compare state pair. A plan does
// two endpoint lookups, up to 2*16 walk lookups, a common ancestor search and
// one generate and output state pair per result step. The request queue keeps
// accepting up to four requests meanwhile.
module hsm_transition_planner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  hsmtp_req_if.sink   req_i,
  hsmtp_rsp_if.source rsp_o
);
  import hsmtp_pkg::*;

  logic [31:0] root_q;
  queue_head_t head;
  logic        pop;

  // hold the root address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) root_q <= RootReset;
    else if (cfg_we_i) root_q <= cfg_wdata_i;
  end

  hsmtp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  hsmtp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .root_i (root_q),
    .head_i (head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );
endmodule

[bench/hsm_transition_planner_unit_test.sv]
// ----------------------------------------------------------------------------
// hsm_transition_planner_unit_test: self-checking bench of the transition planner
// Loads state trees, sends plan and query requests, and compares each step
// against an in-bench planner with its own state table and root register.
// ----------------------------------------------------------------------------
module hsm_transition_planner_unit_test;
  import hsmtp_pkg::*;

  localparam int WatchdogLimit = 60000;
  localparam int SettleCycles  = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  hsmtp_req_if req_if ();
  hsmtp_rsp_if rsp_if ();

  hsm_transition_planner_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Planner mirror: state table and root register
  logic [31:0] mirror_handler [NumStates];
  logic [31:0] mirror_parent  [NumStates];
  logic [8:0]  mirror_code    [NumStates];
  logic        mirror_known   [NumStates];
  logic [31:0] mirror_root;

  rsp_t        pending_steps[$];
  logic [31:0] tree_states[$];

  bit sender_idles;
  bit sink_stalls;
  int mismatches;
  int steps_checked;
  int loads_sent;
  int plans_sent;
  int queries_sent;
  int others_sent;
  int quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int lookup_slot(input logic [31:0] addr);
    for (int i = 0; i < NumStates; i++) begin
      if (mirror_known[i] && mirror_handler[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic void trace_ancestors(input logic [31:0] start,
                                          ref logic [31:0] chain[$]);
    logic [31:0] cur;
    int          s;
    chain.delete();
    cur = start;
    while (cur != 32'd0 && chain.size() < MaxDepth) begin
      chain = {chain, cur};
      if (cur == mirror_root) break;
      s = lookup_slot(cur);
      if (s < 0) break;
      cur = mirror_parent[s];
    end
  endfunction

  function automatic bit chain_holds(ref logic [31:0] chain[$], input logic [31:0] addr);
    foreach (chain[i]) begin
      if (chain[i] == addr) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t make_step(input step_kind_e k, input logic [31:0] st,
                                     input logic [7:0] code);
    rsp_t r;
    r.kind  = k;
    r.state = st;
    r.code  = code;
    r.last  = 1'b0;
    return r;
  endfunction

  // Work out the steps of one accepted request and update the mirror
  function automatic void predict_request(input req_t r);
    rsp_t        steps[$];
    logic [31:0] from_chain[$];
    logic [31:0] to_chain[$];
    logic [31:0] common;
    int          s;
    int          stop;
    bit          from_ok;
    bit          to_ok;
    case (r.kind)
      REQ_LOAD: begin
        mirror_handler[r.slot] = r.handler;
        mirror_parent[r.slot]  = r.parent;
        mirror_code[r.slot]    = r.code;
        mirror_known[r.slot]   = 1'b1;
      end
      REQ_QUERY: begin
        s = lookup_slot(r.from_state);
        if (s >= 0 && !mirror_code[s][8]) begin
          steps = {steps, make_step(KIND_FOUND, r.from_state, mirror_code[s][7:0])};
        end else begin
          steps = {steps, make_step(KIND_ABSENT, r.from_state, 8'd0)};
        end
      end
      REQ_PLAN: begin
        from_ok = lookup_slot(r.from_state) >= 0 || r.from_state == mirror_root;
        to_ok   = lookup_slot(r.to_state) >= 0 || r.to_state == mirror_root;
        if (from_ok && to_ok) begin
          trace_ancestors(r.from_state, from_chain);
          trace_ancestors(r.to_state, to_chain);
          common = 32'd0;
          foreach (from_chain[i]) begin
            if (chain_holds(to_chain, from_chain[i])) begin
              common = from_chain[i];
              break;
            end
          end
          // Exit from the current state up to the common ancestor
          foreach (from_chain[i]) begin
            if (from_chain[i] == common || steps.size() >= MaxResults) break;
            steps = {steps, make_step(KIND_EXIT, from_chain[i], 8'd0)};
          end
          // Enter from the outermost state down to the target
          stop = 0;
          while (stop < to_chain.size() && to_chain[stop] != common) stop++;
          for (int i = stop; i > 0 && steps.size() < MaxResults; i--) begin
            steps = {steps, make_step(KIND_ENTRY, to_chain[i-1], 8'd0)};
          end
        end
        if (steps.size() == 0) steps = {steps, make_step(KIND_NONE, 32'd0, 8'd0)};
      end
      default: ;
    endcase
    if (steps.size() > 0) steps[steps.size()-1].last = 1'b1;
    foreach (steps[i]) pending_steps = {pending_steps, steps[i]};
  endfunction

  // Send one request, predict it at acceptance, then maybe idle
  task automatic send_request(input req_t r);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= r.kind;
    req_if.slot          <= r.slot;
    req_if.entry_handler <= r.handler;
    req_if.entry_parent  <= r.parent;
    req_if.load_code     <= r.code;
    req_if.from_state    <= r.from_state;
    req_if.to_state      <= r.to_state;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_request(r);
    case (r.kind)
      REQ_LOAD:  loads_sent++;
      REQ_PLAN:  plans_sent++;
      REQ_QUERY: queries_sent++;
      default:   others_sent++;
    endcase
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  function automatic req_t make_req(input req_type_e k);
    req_t r;
    r.kind       = k;
    r.slot       = SlotW'($urandom_range(0, NumStates - 1));
    r.handler    = $urandom;
    r.parent     = $urandom;
    r.code       = 9'($urandom_range(0, 511));
    r.from_state = $urandom;
    r.to_state   = $urandom;
    return r;
  endfunction

  task automatic load_state(input int slot, input logic [31:0] h, input logic [31:0] p,
                            input logic [8:0] code);
    req_t r;
    r = make_req(REQ_LOAD);
    r.slot    = SlotW'(slot);
    r.handler = h;
    r.parent  = p;
    r.code    = code;
    send_request(r);
  endtask

  task automatic plan_between(input logic [31:0] from_st, input logic [31:0] to_st);
    req_t r;
    r = make_req(REQ_PLAN);
    r.from_state = from_st;
    r.to_state   = to_st;
    send_request(r);
  endtask

  task automatic query_code(input logic [31:0] st);
    req_t r;
    r = make_req(REQ_QUERY);
    r.from_state = st;
    send_request(r);
  endtask

  // Drop valid, wait for every step, let trailing loads finish
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [31:0] value);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    mirror_root = value;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_state();
    if (tree_states.size() == 0 || $urandom_range(0, 9) == 0) return mirror_root;
    return tree_states[$urandom_range(0, tree_states.size() - 1)];
  endfunction

  // Load a random tree hanging off the root
  task automatic grow_tree(input int count);
    logic [31:0] h;
    logic [31:0] p;
    tree_states.delete();
    for (int i = 0; i < count; i++) begin
      h = $urandom;
      p = (i == 0 || $urandom_range(0, 4) == 0) ? mirror_root : pick_state();
      load_state($urandom_range(0, NumStates - 1), h, p, 9'($urandom_range(0, 511)));
      tree_states = {tree_states, h};
    end
  endtask

  // Directed: extremes, every request type, unknown endpoints, equal endpoints
  task automatic test_directed();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    query_code(32'h1234_5678);
    plan_between(mirror_root, mirror_root);
    plan_between(32'h0BAD_0001, mirror_root);
    a = 32'hFFFF_FFFF;
    b = 32'h0000_0001;
    c = 32'h5555_AAAA;
    load_state(0, a, mirror_root, 9'h0FF);
    load_state(63, b, a, 9'h000);
    load_state(17, c, a, 9'h1FF);
    load_state(42, 32'hAAAA_5555, b, 9'h100);
    query_code(a);
    query_code(b);
    query_code(c);
    query_code(32'hAAAA_5555);
    plan_between(32'hAAAA_5555, c);
    plan_between(c, 32'hAAAA_5555);
    plan_between(b, b);
    plan_between(mirror_root, 32'hAAAA_5555);
    plan_between(32'hAAAA_5555, mirror_root);
    plan_between(b, 32'hDEAD_BEEF);
    plan_between(32'd0, b);
    send_request(make_req(REQ_NONE));
    // Duplicate handler: the lower slot wins
    load_state(50, c, b, 9'h07);
    query_code(c);
    plan_between(c, 32'hAAAA_5555);
  endtask

  // Parent loop truncates both walks at full depth; zero handler gives empty chain
  task automatic test_truncation();
    load_state(5, 32'h0000_1111, 32'h0000_2222, 9'h01);
    load_state(6, 32'h0000_2222, 32'h0000_1111, 9'h02);
    plan_between(32'h0000_1111, 32'h0000_2222);
    plan_between(32'h0000_2222, 32'hFFFF_FFFF);
    load_state(7, 32'd0, 32'h0000_1111, 9'h03);
    plan_between(32'd0, 32'h0000_2222);
    plan_between(32'h0000_2222, 32'd0);
  endtask

  // Root register extremes
  task automatic test_root_settings();
    write_root(32'd0);
    grow_tree(6);
    plan_between(pick_state(), pick_state());
    plan_between(tree_states[5], tree_states[0]);
    query_code(tree_states[2]);
    write_root(32'hFFFF_FFFF);
    plan_between(tree_states[4], 32'hFFFF_FFFF);
    plan_between(32'hFFFF_FFFF, tree_states[3]);
    plan_between(tree_states[1], tree_states[5]);
  endtask

  // Random trees with plans, queries, reloads and noise
  task automatic test_random_phase(input int count);
    req_t r;
    int   pick;
    grow_tree($urandom_range(8, 14));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        plan_between(pick_state(), pick_state());
      end else if (pick < 72) begin
        query_code($urandom_range(0, 7) == 0 ? $urandom : pick_state());
      end else if (pick < 85) begin
        r = make_req(REQ_LOAD);
        if ($urandom_range(0, 1)) r.handler = pick_state();
        r.parent = $urandom_range(0, 5) == 0 ? r.parent : pick_state();
        send_request(r);
      end else if (pick < 92) begin
        plan_between($urandom_range(0, 1) ? $urandom : pick_state(),
                     $urandom_range(0, 1) ? $urandom : pick_state());
      end else if (pick < 96) begin
        send_request(make_req(REQ_NONE));
      end else begin
        plan_between(32'd0, pick_state());
      end
    end
  endtask

  // Result sink: random stall bursts while enabled
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Check each accepted step against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      steps_checked++;
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected step: kind %0d state %h code %0d last %b",
                   rsp_if.step_kind, rsp_if.step_state, rsp_if.code_value, rsp_if.last);
      end else begin
        want = pending_steps.pop_front();
        if (rsp_if.step_kind !== want.kind || rsp_if.step_state !== want.state ||
            rsp_if.code_value !== want.code || rsp_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("step mismatch: exp %0d %h %0d %b, got %0d %h %0d %b",
                     want.kind, want.state, want.code, want.last, rsp_if.step_kind,
                     rsp_if.step_state, rsp_if.code_value, rsp_if.last);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d steps outstanding", pending_steps.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= 32'd0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_LOAD;
    req_if.slot          <= '0;
    req_if.entry_handler <= '0;
    req_if.entry_parent  <= '0;
    req_if.load_code     <= '0;
    req_if.from_state    <= '0;
    req_if.to_state      <= '0;
    mirror_root          = RootReset;
    for (int i = 0; i < NumStates; i++) mirror_known[i] = 1'b0;
    sender_idles = 1'b1;
    sink_stalls  = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_truncation();
    test_root_settings();
    write_root($urandom);
    test_random_phase(25);
    write_root(RootReset);
    test_random_phase(25);
    write_root($urandom);
    test_random_phase(25);
    // Last stretch runs at full rate on both sides
    write_root(RootReset);
    sender_idles = 1'b0;
    sink_stalls  = 1'b0;
    test_random_phase(25);
    drain_requests();

    $display("covered %0d loads, %0d plans, %0d queries, %0d unused-type requests",
             loads_sent, plans_sent, queries_sent, others_sent);
    $display("checked %0d steps across several root settings, %0d mismatches",
             steps_checked, mismatches);
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
